FILE: design/pcdp_pkg.sv
// Package for the position cache: types, constants and score helpers.
`default_nettype none
package pcdp_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int LAST_IDX      = TABLE_ENTRIES - 1;
	localparam logic [5:0] DEPTH_MAX = 6'h3F;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_PROBE = 2'd0,
		OP_STORE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic {
		CFG_MATE_VALUE = 1'b0,
		CFG_MAX_PLY    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} st_t;

	typedef struct packed {
		op_t                op;
		logic [63:0]        key;
		logic [7:0]         ply;
		logic [15:0]        store_move;
		logic signed [7:0]  store_depth;
		logic signed [15:0] store_score;
		logic [1:0]         store_flag;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        move;
		logic signed [15:0] score;
		logic [1:0]         flag;
		logic [5:0]         depth;
	} rsp_t;

	// info: flag in [7:6], depth in [5:0]; zero info means empty
	typedef struct packed {
		logic [63:0] key;
		logic [15:0] move;
		logic [15:0] score;
		logic [7:0]  info;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   we;
		entry_t data;
	} wr_t;

	// XOR fold of the four key words, masked and reduced into the table
	function automatic idx_t slot_of(logic [63:0] key);
		logic [15:0] fold;
		logic [16:0] m;
		fold = key[15:0] ^ key[31:16] ^ key[47:32] ^ key[63:48];
		m = {1'b0, fold & 16'(LAST_IDX)};
		if (m >= 17'(TABLE_ENTRIES)) begin
			m = m - 17'(TABLE_ENTRIES);
		end
		return m[IDX_W-1:0];
	endfunction

	// to_node = 1: root-relative -> node-relative; 0: the reverse
	function automatic logic [15:0] mate_shift(logic [15:0] s, logic [7:0] ply,
			logic [14:0] mate, logic [9:0] maxp, logic to_node);
		logic signed [16:0] sx;
		logic signed [16:0] hi;
		logic signed [16:0] lo;
		logic [15:0] up;
		logic [15:0] dn;
		sx = {s[15], s};
		hi = $signed({2'b00, mate}) - $signed({7'b0, maxp});
		lo = -hi;
		up = s + {8'b0, ply};
		dn = s - {8'b0, ply};
		if (sx >= hi) begin
			return to_node ? up : dn;
		end else if (sx <= lo) begin
			return to_node ? dn : up;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: design/pcdp_ram.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module pcdp_ram
	import pcdp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   we,
	input  wire idx_t   waddr,
	input  wire entry_t wdata,
	input  wire logic   re,
	input  wire idx_t   raddr,
	output entry_t      rdata
);

	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = entry_t'(rdata_q);

endmodule
`default_nettype wire

FILE: design/pcdp_upd.sv
// Probe result and store update from the entry read out of memory.
`default_nettype none
module pcdp_upd
	import pcdp_pkg::*;
(
	input  wire req_t        item,
	input  wire entry_t      cur,
	input  wire logic [14:0] mate_value,
	input  wire logic [9:0]  max_ply,
	output rsp_t             result,
	output wr_t              wr
);

	logic              match;
	logic signed [8:0] dep_new;
	logic signed [8:0] dep_old;
	logic [5:0]        dep_sat;

	assign match   = (cur.info != 8'd0) && (cur.key == item.key);
	assign dep_new = {item.store_depth[7], item.store_depth};
	assign dep_old = {3'b000, cur.info[5:0]};
	assign dep_sat = (dep_new > 9'sd63) ? DEPTH_MAX : item.store_depth[5:0];

	always_comb begin
		result = '0;
		if (item.op == OP_PROBE && match) begin
			result.hit   = 1'b1;
			result.move  = cur.move;
			result.score = mate_shift(cur.score, item.ply, mate_value, max_ply, 1'b0);
			result.flag  = cur.info[7:6];
			result.depth = cur.info[5:0];
		end
	end

	always_comb begin
		wr.we         = (item.op == OP_STORE) && (dep_new >= dep_old);
		wr.data.key   = item.key;
		wr.data.move  = item.store_move;
		wr.data.score = mate_shift(item.store_score, item.ply, mate_value, max_ply, 1'b1);
		wr.data.info  = {item.store_flag, dep_sat};
	end

endmodule
`default_nettype wire

FILE: design/position_cache_depth_preferred_core.sv
// Top level of the position cache: control, registers and output stage.
`default_nettype none
// An accepted item reads its slot from memory; once the output register is free, the
// update state updates that slot and loads the result. No new item is taken till then.
// A clear item walks all TABLE_ENTRIES slots, one per cycle, after its result.
// Reset: asynchronous, active low; control and config registers return to defaults
//   and a clearing pass over all TABLE_ENTRIES slots zeroes memory before the first item.
module position_cache_depth_preferred_core
	import pcdp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire cfg_idx_t    cfg_index,
	input  wire logic [14:0] cfg_data
);

	st_t         state_q, state_d;
	idx_t        clr_q;
	idx_t        slot_q;
	req_t        item_q;
	logic [14:0] mate_q;
	logic [9:0]  maxp_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	entry_t      rd_entry;
	rsp_t        result;
	wr_t         upd;

	logic        accept;
	logic        rsp_load;
	logic        mem_we;
	idx_t        mem_waddr;
	entry_t      mem_wdata;
	logic        clr_last;

	// config registers are always writable; the host is to write only when idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	assign accept   = req_valid && req_ready;
	assign clr_last = (clr_q == idx_t'(LAST_IDX));

	pcdp_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (slot_of(req.key)),
		.rdata (rd_entry)
	);

	pcdp_upd u_upd (
		.item       (item_q),
		.cur        (rd_entry),
		.mate_value (mate_q),
		.max_ply    (maxp_q),
		.result     (result),
		.wr         (upd)
	);

	// next state, handshake and memory write select
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = upd.data;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// output register decouples: accept even if a result waits
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				// read data holds while the output register is still full
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					mem_we   = upd.we;
					state_d  = (item_q.op == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep pointer, back to zero at the end of each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_last ? '0 : clr_q + idx_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_q <= 15'd32000;
			maxp_q <= 10'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MATE_VALUE: mate_q <= cfg_data;
				CFG_MAX_PLY:    maxp_q <= cfg_data[9:0];
				default:        ;
			endcase
		end
	end

	// item held for the update state
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			slot_q <= slot_of(req.key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an accepted item always goes to the update state next
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOK)
		else $error("accepted item did not reach update cycle");

	// the memory is written only by the sweep or by a store being retired
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR) || (rsp_load && item_q.op == OP_STORE))
		else $error("unexpected memory write");

	// only a probe can report a hit
	a_hit_probe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && item_q.op != OP_PROBE |=> !rsp.hit)
		else $error("hit reported for a non-probe item");

	// no item is taken while the table is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !accept)
		else $error("item accepted during clearing pass");

endmodule
`default_nettype wire

FILE: verif/tb_position_cache_depth_preferred_core.sv
// Testbench for the position cache: directed and random probe/store/clear traffic.
module tb_position_cache_depth_preferred_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pcdp_pkg::*;

	// The op encoding leaves one code unused; the block answers it with a miss.
	localparam op_t OP_UNUSED = op_t'(2'd3);

	// Generous bound on the whole run, even with every clear walking the table and the
	// receiver at its slowest.
	localparam int CYCLE_LIMIT = 600000;
	localparam int KEY_POOL_SIZE = 32;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [14:0] cfg_data;

	// Shadow of the cache contents and registers, updated as items are accepted.
	entry_t      cache_mem [TABLE_ENTRIES];
	logic [14:0] mate_cfg = 15'd32000;
	logic [9:0]  maxply_cfg = 10'd64;

	rsp_t        pending_lookups [$];
	rsp_t        want_rsp;
	logic [63:0] key_pool [KEY_POOL_SIZE];
	int          burst_left = 0;
	int          mismatch_count = 0;
	logic [31:0] cycle_count = 0;
	logic [7:0]  ready_mask = 8'hFF;

	position_cache_depth_preferred_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Receiver back-pressure: when cycle_count[5:0] is zero, pick a new 8-bit ready mask.
	// All-ones gives stretches with no stalls, 8'h01 gives the longest stalls.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count[5:0] == 6'd0) begin
			case ($urandom_range(0, 3))
				0: begin
					ready_mask <= 8'hFF;
				end
				1: begin
					ready_mask <= 8'h01;
				end
				default: begin
					ready_mask <= 8'($urandom) | 8'h01;
				end
			endcase
		end
		rsp_ready <= ready_mask[cycle_count[2:0]];
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, pending_lookups.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Result checker: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch("unexpected result, hit", rsp.hit, 0);
			end else begin
				want_rsp = pending_lookups.pop_front();
				if (rsp.hit !== want_rsp.hit)
					report_mismatch("hit", rsp.hit, want_rsp.hit);
				if (rsp.move !== want_rsp.move)
					report_mismatch("move", rsp.move, want_rsp.move);
				if (rsp.score !== want_rsp.score)
					report_mismatch("score", rsp.score, want_rsp.score);
				if (rsp.flag !== want_rsp.flag)
					report_mismatch("flag", rsp.flag, want_rsp.flag);
				if (rsp.depth !== want_rsp.depth)
					report_mismatch("depth", rsp.depth, want_rsp.depth);
			end
		end
	end

	// Slot = XOR of the four key words, masked, then folded into range.
	function automatic int cache_slot(input logic [63:0] key);
		int folded;
		folded = int'(key[15:0] ^ key[31:16] ^ key[47:32] ^ key[63:48]);
		folded = folded & (TABLE_ENTRIES - 1);
		return folded % TABLE_ENTRIES;
	endfunction

	// Mate scores move by ply: toward_node pushes a winning mate away from zero
	// on the way in, the reverse on the way out. Limits do not wrap; scores do.
	function automatic logic [15:0] mate_adjust(input logic [15:0] s, input logic [7:0] ply,
			input bit toward_node);
		int sc;
		int hi;
		int p;
		sc = $signed(s);
		hi = int'(mate_cfg) - int'(maxply_cfg);
		p = int'(ply);
		if (sc >= hi)
			return 16'(toward_node ? sc + p : sc - p);
		if (sc <= -hi)
			return 16'(toward_node ? sc - p : sc + p);
		return s;
	endfunction

	// Applies one item to the shadow cache and returns the result it must give.
	function automatic rsp_t predict_lookup(input req_t item);
		rsp_t   res;
		entry_t slot;
		int     idx;
		int     dep;
		res = '0;
		idx = cache_slot(item.key);
		slot = cache_mem[idx];
		case (item.op)
			OP_PROBE: begin
				if (slot.info != 8'd0 && slot.key == item.key) begin
					res.hit = 1'b1;
					res.move = slot.move;
					res.score = mate_adjust(slot.score, item.ply, 1'b0);
					res.flag = slot.info[7:6];
					res.depth = slot.info[5:0];
				end
			end
			OP_STORE: begin
				dep = $signed(item.store_depth);
				// depth-preferred: a shallower store loses; equal depth replaces
				if (dep >= int'(slot.info[5:0])) begin
					if (dep > 63)
						dep = 63;
					slot.key = item.key;
					slot.move = item.store_move;
					slot.score = mate_adjust(item.store_score, item.ply, 1'b1);
					slot.info = {item.store_flag, 6'(dep)};
					cache_mem[idx] = slot;
				end
			end
			OP_CLEAR: begin
				foreach (cache_mem[i])
					cache_mem[i] = '0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic req_t make_request(input op_t op, input logic [63:0] key,
			input logic [7:0] ply, input logic [15:0] move, input logic [7:0] depth,
			input logic [15:0] score, input logic [1:0] flag);
		req_t item;
		item.op = op;
		item.key = key;
		item.ply = ply;
		item.store_move = move;
		item.store_depth = depth;
		item.store_score = score;
		item.store_flag = flag;
		return item;
	endfunction

	// Sender: bursts of random length separated by random gaps. Called in the
	// time step right after an edge; valid stays high across back-to-back items.
	task automatic send_request(input req_t item);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		req <= item;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!(req_valid && req_ready));
		burst_left--;
		pending_lookups.push_back(predict_lookup(item));
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		burst_left = 0;
		while (pending_lookups.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// A clear keeps walking the table after its result, so give it a full pass
	// before touching the registers.
	task automatic settle_cache();
		drain_results();
		repeat (TABLE_ENTRIES + 16) @(posedge clk);
	endtask

	// Both registers in one go so cfg_valid is never dropped and raised in one step.
	task automatic apply_config(input logic [14:0] mate, input logic [14:0] maxp);
		cfg_index <= CFG_MATE_VALUE;
		cfg_data <= mate;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!(cfg_valid && cfg_ready));
		mate_cfg = mate;
		cfg_index <= CFG_MAX_PLY;
		cfg_data <= maxp;
		do begin
			@(posedge clk);
		end while (!(cfg_valid && cfg_ready));
		maxply_cfg = maxp[9:0];
		cfg_valid <= 1'b0;
	endtask

	// Half the pool are fresh keys; the other half share a slot with one of them
	// (words 2 and 3 flipped by the same mask, so the fold is unchanged).
	task automatic refill_key_pool();
		logic [15:0] flip;
		for (int i = 0; i < KEY_POOL_SIZE / 2; i++) begin
			key_pool[i] = {$urandom, $urandom};
			flip = 16'($urandom_range(1, 16'hFFFF));
			key_pool[i + KEY_POOL_SIZE / 2] = key_pool[i] ^ {flip, flip, 32'h0};
		end
	endtask

	function automatic req_t random_request(input int clear_one_in);
		req_t item;
		int   pick;
		int   hi;
		hi = int'(mate_cfg) - int'(maxply_cfg);
		pick = $urandom_range(0, 99);
		if (clear_one_in > 0 && $urandom_range(1, clear_one_in) == 1)
			item.op = OP_CLEAR;
		else if (pick < 3)
			item.op = OP_UNUSED;
		else if (pick < 50)
			item.op = OP_PROBE;
		else
			item.op = OP_STORE;
		item.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
			: key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
		case ($urandom_range(0, 5))
			0: item.ply = 8'd0;
			1: item.ply = 8'hFF;
			default: item.ply = 8'($urandom);
		endcase
		item.store_move = 16'($urandom);
		case ($urandom_range(0, 3))
			0: item.store_depth = 8'($urandom);
			1: item.store_depth = 8'($urandom_range(0, 63));
			2: item.store_depth = 8'($urandom_range(60, 127));
			default: item.store_depth = 8'($urandom_range(0, 3));
		endcase
		// bias scores toward the edges of the mate windows
		case ($urandom_range(0, 5))
			0, 1: item.store_score = 16'($urandom);
			2: item.store_score = 16'(hi + int'($urandom_range(0, 4)) - 2);
			3: item.store_score = 16'(-hi + int'($urandom_range(0, 4)) - 2);
			4: item.store_score = 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
			default: item.store_score = 16'($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
		endcase
		item.store_flag = 2'($urandom);
		return item;
	endfunction

	task automatic run_traffic(input int count, input int clear_one_in);
		for (int i = 0; i < count; i++)
			send_request(random_request(clear_one_in));
	endtask

	// Hand-picked sequence under the reset register values (mate window from
	// 31936 up and from -31936 down): replacement rules, saturation, empty info,
	// score wrap at both ends, the unused op and a clear.
	task automatic test_directed();
		logic [63:0] key_a;
		logic [63:0] key_a2;
		logic [63:0] key_ones;
		logic [63:0] key_zero;
		logic [63:0] key_c;
		key_a = 64'h0123_4567_89AB_CDEF;
		key_a2 = key_a ^ 64'h5A5A_5A5A_0000_0000;   // same slot as key_a
		key_ones = '1;                              // folds to slot 0
		key_zero = '0;                              // also slot 0
		key_c = 64'h0000_0000_0000_0F0F;
		send_request(make_request(OP_PROBE, key_a, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_STORE, key_a, 8'd3, 16'hFFFF, 8'sd10, 16'sd500, 2'd1));
		send_request(make_request(OP_PROBE, key_a, 8'd7, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_PROBE, key_a2, 8'd7, 16'h0, 8'sd0, 16'sd0, 2'd0));
		// shallower store to the same slot is dropped
		send_request(make_request(OP_STORE, key_a2, 8'd0, 16'h1234, 8'sd5, 16'sd1, 2'd3));
		send_request(make_request(OP_PROBE, key_a, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		// equal depth wins; score exactly on the winning limit
		send_request(make_request(OP_STORE, key_a2, 8'd5, 16'h0001, 8'sd10, 16'sd31936, 2'd2));
		send_request(make_request(OP_PROBE, key_a, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_PROBE, key_a2, 8'd2, 16'h0, 8'sd0, 16'sd0, 2'd0));
		// depth above 63 saturates; top score plus ply wraps negative
		send_request(make_request(OP_STORE, key_ones, 8'hFF, 16'h0, 8'sd127, 16'h7FFF, 2'd3));
		send_request(make_request(OP_PROBE, key_ones, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_PROBE, key_zero, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		// negative depths never land
		send_request(make_request(OP_STORE, key_zero, 8'd1, 16'hA5A5, 8'h80, 16'sd0, 2'd1));
		send_request(make_request(OP_STORE, key_zero, 8'd1, 16'hA5A5, 8'hFF, 16'sd0, 2'd1));
		// depth 0, flag 0 writes an empty-looking slot
		send_request(make_request(OP_STORE, key_c, 8'd4, 16'h5555, 8'sd0, -16'sd100, 2'd0));
		send_request(make_request(OP_PROBE, key_c, 8'd4, 16'h0, 8'sd0, 16'sd0, 2'd0));
		// most negative score minus ply wraps positive
		send_request(make_request(OP_STORE, key_c, 8'hFF, 16'hAAAA, 8'sd0, 16'h8000, 2'd2));
		send_request(make_request(OP_PROBE, key_c, 8'hFF, 16'h0, 8'sd0, 16'sd0, 2'd0));
		// losing limit exactly
		send_request(make_request(OP_STORE, key_a, 8'd9, 16'h7E7E, 8'sd63, -16'sd31936, 2'd0));
		send_request(make_request(OP_PROBE, key_a, 8'd9, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_UNUSED, key_a, 8'd9, 16'hFFFF, 8'sd63, 16'sd7, 2'd3));
		send_request(make_request(OP_CLEAR, key_zero, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_PROBE, key_a2, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_PROBE, key_c, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
		send_request(make_request(OP_PROBE, key_ones, 8'd0, 16'h0, 8'sd0, 16'sd0, 2'd0));
	endtask

	// Register extremes: widest and narrowest windows, a window that swallows every
	// score (mate 0, max ply 1023), upper data bits of max ply ignored.
	task automatic test_mate_limits();
		logic [14:0] mate_set [5];
		logic [14:0] ply_set [5];
		mate_set = '{15'h7FFF, 15'd0, 15'd0, 15'h7FFF, 15'($urandom)};
		ply_set = '{15'h7FFF, 15'd0, 15'd1023, 15'h7C00, 15'($urandom)};
		for (int i = 0; i < 5; i++) begin
			settle_cache();
			apply_config(mate_set[i], ply_set[i]);
			refill_key_pool();
			run_traffic(65, 40);
		end
	endtask

	// Bulk random traffic; the sender waits once mid-run for every result.
	task automatic test_random_traffic();
		settle_cache();
		apply_config(15'($urandom_range(20000, 32767)), 15'($urandom_range(0, 1023)));
		refill_key_pool();
		run_traffic(250, 150);
		drain_results();
		run_traffic(250, 150);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MATE_VALUE;
		cfg_data = '0;
		foreach (cache_mem[i])
			cache_mem[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its memory after reset; handshakes wait that out
		@(posedge clk);
		test_directed();
		test_mate_limits();
		test_random_traffic();
		drain_results();
		repeat (32) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
